FILE: rtl/hta_pkg.sv
package hta_pkg;

    // table geometry
    localparam int ID_SPACE = 256;
    localparam int SLOTS    = 256;
    localparam int ID_W     = $clog2(ID_SPACE);
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);

    // free-id search tree: groups of live bits
    localparam int GRP      = 16;
    localparam int GRP_W    = $clog2(GRP);
    localparam int NGRP     = ID_SPACE / GRP;
    localparam int NGRP_W   = $clog2(NGRP);

    // request kinds
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    // live bit updates from the sequencer
    typedef struct packed {
        logic            set_en;
        logic [ID_W-1:0] set_id;
        logic            clr_en;
        logic [ID_W-1:0] clr_id;
    } live_upd_t;

    // lowest free id and lookup answer back to the sequencer
    typedef struct packed {
        logic            free_found;
        logic [ID_W-1:0] free_id;
        logic            qry_live;
    } live_info_t;

endpackage

FILE: rtl/hta_ram.sv
module hta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/hta_live_map.sv
module hta_live_map (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hta_pkg::live_upd_t        upd,
    input  logic [hta_pkg::ID_W-1:0]  qry_id,
    output hta_pkg::live_info_t       info
);

    logic [hta_pkg::ID_SPACE-1:0] live_reg;
    logic [hta_pkg::ID_SPACE-1:0] live_next;

    logic [hta_pkg::NGRP-1:0]  grp_free_reg;
    logic [hta_pkg::NGRP-1:0]  grp_free_next;
    logic [hta_pkg::GRP_W-1:0] grp_low_reg  [hta_pkg::NGRP];
    logic [hta_pkg::GRP_W-1:0] grp_low_next [hta_pkg::NGRP];

    logic [hta_pkg::NGRP_W-1:0] pick_grp;
    logic                       pick_found;

    // live bit per id, id 0 never live
    always_comb
    begin
        live_next = live_reg;
        if (upd.set_en)
        begin
            live_next[upd.set_id] = 1'b1;
        end
        if (upd.clr_en)
        begin
            live_next[upd.clr_id] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    // first tree level: lowest free bit inside each group, registered
    always_comb
    begin
        for (int g = 0; g < hta_pkg::NGRP; g++)
        begin
            grp_free_next[g] = 1'b0;
            grp_low_next[g]  = '0;
            for (int b = hta_pkg::GRP - 1; b >= 0; b--)
            begin
                if (!live_reg[g * hta_pkg::GRP + b] && (g * hta_pkg::GRP + b) != 0)
                begin
                    grp_free_next[g] = 1'b1;
                    grp_low_next[g]  = hta_pkg::GRP_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_free_reg <= '0;
        end
        else
        begin
            grp_free_reg <= grp_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_low_reg <= grp_low_next;
    end

    // second tree level: lowest group with a free id
    always_comb
    begin
        pick_found = 1'b0;
        pick_grp   = '0;
        for (int g = hta_pkg::NGRP - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                pick_found = 1'b1;
                pick_grp   = hta_pkg::NGRP_W'(g);
            end
        end
    end

    assign info.free_found = pick_found;
    assign info.free_id    = {pick_grp, grp_low_reg[pick_grp]};
    assign info.qry_live   = live_reg[qry_id];

endmodule

FILE: rtl/handle_table_allocator.sv
// handle table: allocate takes the lowest free id, release swaps the last slot in
// an allocate or invalid release loads its result in the lookup state, a valid release in the
// apply state after the lookup; a result waits in that state while out_stall holds the output
// requests are taken only in idle, so a new request waits until the last has loaded its result,
// and a release waits out the registered read of the id map and slot list
// reset: all ids free and count zero at once; the memories are not cleared
module handle_table_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [7:0]                  release_id,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [7:0]                  handle_id,
    output logic [7:0]                  slot_index,
    output logic                        moved,
    output logic [7:0]                  moved_id,
    output logic [8:0]                  live_count
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOOK  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic                          req_type_reg;
    logic                          req_type_next;
    logic [hta_pkg::ID_W-1:0]      rid_reg;
    logic [hta_pkg::ID_W-1:0]      rid_next;
    logic [hta_pkg::CNT_W-1:0]     count_reg;
    logic [hta_pkg::CNT_W-1:0]     count_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    hta_pkg::status_t              status_reg;
    hta_pkg::status_t              status_next;
    logic [hta_pkg::ID_W-1:0]      handle_id_reg;
    logic [hta_pkg::ID_W-1:0]      handle_id_next;
    logic [hta_pkg::SLOT_W-1:0]    slot_index_reg;
    logic [hta_pkg::SLOT_W-1:0]    slot_index_next;
    logic                          moved_reg;
    logic                          moved_next;
    logic [hta_pkg::ID_W-1:0]      moved_id_reg;
    logic [hta_pkg::ID_W-1:0]      moved_id_next;
    logic [hta_pkg::CNT_W-1:0]     live_count_reg;
    logic [hta_pkg::CNT_W-1:0]     live_count_next;

    logic                          map_we;
    logic [hta_pkg::ID_W-1:0]      map_waddr;
    logic [hta_pkg::SLOT_W-1:0]    map_wdata;
    logic [hta_pkg::SLOT_W-1:0]    map_rdata;
    logic                          dense_we;
    logic [hta_pkg::SLOT_W-1:0]    dense_waddr;
    logic [hta_pkg::ID_W-1:0]      dense_wdata;
    logic [hta_pkg::ID_W-1:0]      dense_rdata;

    logic [hta_pkg::CNT_W-1:0]     last_slot;
    logic                          out_free;
    logic                          do_move;

    hta_pkg::live_upd_t            live_upd;
    hta_pkg::live_info_t           live_info;

    // slot of each live id
    hta_ram #(
        .WIDTH (hta_pkg::SLOT_W),
        .DEPTH (hta_pkg::ID_SPACE)
    ) u_id_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (rid_reg),
        .rdata (map_rdata)
    );

    // id held at each dense slot
    hta_ram #(
        .WIDTH (hta_pkg::ID_W),
        .DEPTH (hta_pkg::SLOTS)
    ) u_dense_ids (
        .clk   (clk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .raddr (last_slot[hta_pkg::SLOT_W-1:0]),
        .rdata (dense_rdata)
    );

    hta_live_map u_live_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (live_upd),
        .qry_id (rid_reg),
        .info   (live_info)
    );

    assign last_slot = count_reg - hta_pkg::CNT_W'(1);
    assign out_free  = !out_valid_reg || !out_stall;
    assign do_move   = {1'b0, map_rdata} != last_slot;
    assign in_stall  = state_reg != S_IDLE;

    // request sequencer: look up, then write back and load the result
    always_comb
    begin
        state_next      = state_reg;
        req_type_next   = req_type_reg;
        rid_next        = rid_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        handle_id_next  = handle_id_reg;
        slot_index_next = slot_index_reg;
        moved_next      = moved_reg;
        moved_id_next   = moved_id_reg;
        live_count_next = live_count_reg;
        map_we          = 1'b0;
        map_waddr       = live_info.free_id;
        map_wdata       = count_reg[hta_pkg::SLOT_W-1:0];
        dense_we        = 1'b0;
        dense_waddr     = count_reg[hta_pkg::SLOT_W-1:0];
        dense_wdata     = live_info.free_id;
        live_upd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_type_next = req_type;
                    rid_next      = release_id;
                    state_next    = S_LOOK;
                end
            end

            S_LOOK:
            begin
                if (req_type_reg == hta_pkg::REQ_ALLOC)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        moved_next      = 1'b0;
                        moved_id_next   = '0;
                        state_next      = S_IDLE;
                        if (count_reg >= hta_pkg::CNT_W'(hta_pkg::SLOTS) ||
                            !live_info.free_found)
                        begin
                            status_next     = hta_pkg::ST_FULL;
                            handle_id_next  = '0;
                            slot_index_next = '0;
                            live_count_next = count_reg;
                        end
                        else
                        begin
                            map_we          = 1'b1;
                            dense_we        = 1'b1;
                            live_upd.set_en = 1'b1;
                            live_upd.set_id = live_info.free_id;
                            count_next      = count_reg + hta_pkg::CNT_W'(1);
                            status_next     = hta_pkg::ST_OK;
                            handle_id_next  = live_info.free_id;
                            slot_index_next = count_reg[hta_pkg::SLOT_W-1:0];
                            live_count_next = count_reg + hta_pkg::CNT_W'(1);
                        end
                    end
                end
                else if (rid_reg == '0 || !live_info.qry_live)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        status_next     = hta_pkg::ST_INVALID;
                        handle_id_next  = '0;
                        slot_index_next = '0;
                        moved_next      = 1'b0;
                        moved_id_next   = '0;
                        live_count_next = count_reg;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    // map and last-slot reads are in flight
                    state_next = S_APPLY;
                end
            end

            S_APPLY:
            begin
                if (out_free)
                begin
                    // move the last entry into the vacated slot
                    map_we          = do_move;
                    map_waddr       = dense_rdata;
                    map_wdata       = map_rdata;
                    dense_we        = do_move;
                    dense_waddr     = map_rdata;
                    dense_wdata     = dense_rdata;
                    live_upd.clr_en = 1'b1;
                    live_upd.clr_id = rid_reg;
                    count_next      = last_slot;
                    out_valid_next  = 1'b1;
                    status_next     = hta_pkg::ST_OK;
                    handle_id_next  = rid_reg;
                    slot_index_next = map_rdata;
                    moved_next      = do_move;
                    moved_id_next   = do_move ? dense_rdata : '0;
                    live_count_next = last_slot;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        rid_reg        <= rid_next;
        status_reg     <= status_next;
        handle_id_reg  <= handle_id_next;
        slot_index_reg <= slot_index_next;
        moved_reg      <= moved_next;
        moved_id_reg   <= moved_id_next;
        live_count_reg <= live_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign handle_id  = handle_id_reg;
    assign slot_index = slot_index_reg;
    assign moved      = moved_reg;
    assign moved_id   = moved_id_reg;
    assign live_count = live_count_reg;

`ifndef SYNTHESIS
    // an accepted request always starts with the lookup step
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_LOOK)
        else $error("accepted request did not enter lookup");

    // a result appears only as a request finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) != S_IDLE)
        else $error("result raised with no request in progress");

    // the live count moves by at most one per request
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            count_reg == $past(count_reg) + 9'd1 || count_reg == $past(count_reg) - 9'd1)
        else $error("live count jumped");

    // a successful result never names id 0
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == hta_pkg::ST_OK |-> handle_id_reg != '0)
        else $error("ok result with id 0");

    // a moved entry is a live id other than the released one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && moved_reg |->
            moved_id_reg != '0 && moved_id_reg != handle_id_reg)
        else $error("bad moved id");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int ITEM_TARGET = 1700;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 20;

    // one result of the handle table
    typedef struct {
        hta_pkg::status_t status;
        logic [7:0]       handle_id;
        logic [7:0]       slot_index;
        logic             moved;
        logic [7:0]       moved_id;
        logic [8:0]       live_count;
    } handle_result_t;

    // one row of the directed plan
    typedef struct {
        logic           kind;
        logic [7:0]     rid;
        bit             literal;
        handle_result_t want;
    } plan_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       req_type = 1'b0;
    logic [7:0] release_id = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] status;
    logic [7:0] handle_id;
    logic [7:0] slot_index;
    logic       moved;
    logic [7:0] moved_id;
    logic [8:0] live_count;

    // shadow copy of the table
    bit live_flag [hta_pkg::ID_SPACE];
    int slot_of_id [hta_pkg::ID_SPACE];
    int id_in_slot [hta_pkg::SLOTS];
    int live_total = 0;

    handle_result_t pending_results [$];
    handle_result_t head_result;
    int  error_count = 0;
    int  accepted = 0;
    int  result_serial = 0;
    int  cycle_count = 0;
    int  stall_run = 0;
    bit  idle_on = 1'b1;

    plan_row_t plan [20] = '{
        '{hta_pkg::REQ_RELEASE, 8'h00, 1'b1, '{hta_pkg::ST_INVALID, 8'd0, 8'd0, 1'b0, 8'd0, 9'd0}},
        '{hta_pkg::REQ_RELEASE, 8'hFF, 1'b1, '{hta_pkg::ST_INVALID, 8'd0, 8'd0, 1'b0, 8'd0, 9'd0}},
        '{hta_pkg::REQ_ALLOC,   8'h00, 1'b1, '{hta_pkg::ST_OK,      8'd1, 8'd0, 1'b0, 8'd0, 9'd1}},
        '{hta_pkg::REQ_ALLOC,   8'hFF, 1'b1, '{hta_pkg::ST_OK,      8'd2, 8'd1, 1'b0, 8'd0, 9'd2}},
        '{hta_pkg::REQ_ALLOC,   8'h55, 1'b1, '{hta_pkg::ST_OK,      8'd3, 8'd2, 1'b0, 8'd0, 9'd3}},
        '{hta_pkg::REQ_ALLOC,   8'hAA, 1'b1, '{hta_pkg::ST_OK,      8'd4, 8'd3, 1'b0, 8'd0, 9'd4}},
        '{hta_pkg::REQ_RELEASE, 8'h04, 1'b1, '{hta_pkg::ST_OK,      8'd4, 8'd3, 1'b0, 8'd0, 9'd3}},
        '{hta_pkg::REQ_RELEASE, 8'h01, 1'b1, '{hta_pkg::ST_OK,      8'd1, 8'd0, 1'b1, 8'd3, 9'd2}},
        '{hta_pkg::REQ_RELEASE, 8'h01, 1'b1, '{hta_pkg::ST_INVALID, 8'd0, 8'd0, 1'b0, 8'd0, 9'd2}},
        '{hta_pkg::REQ_RELEASE, 8'h7F, 1'b1, '{hta_pkg::ST_INVALID, 8'd0, 8'd0, 1'b0, 8'd0, 9'd2}},
        '{hta_pkg::REQ_ALLOC,   8'h00, 1'b0, '{hta_pkg::ST_OK,      8'd0, 8'd0, 1'b0, 8'd0, 9'd0}},
        '{hta_pkg::REQ_ALLOC,   8'h00, 1'b0, '{hta_pkg::ST_OK,      8'd0, 8'd0, 1'b0, 8'd0, 9'd0}},
        '{hta_pkg::REQ_RELEASE, 8'h02, 1'b0, '{hta_pkg::ST_OK,      8'd0, 8'd0, 1'b0, 8'd0, 9'd0}},
        '{hta_pkg::REQ_RELEASE, 8'h80, 1'b0, '{hta_pkg::ST_OK,      8'd0, 8'd0, 1'b0, 8'd0, 9'd0}},
        '{hta_pkg::REQ_RELEASE, 8'h03, 1'b0, '{hta_pkg::ST_OK,      8'd0, 8'd0, 1'b0, 8'd0, 9'd0}},
        '{hta_pkg::REQ_ALLOC,   8'hFF, 1'b0, '{hta_pkg::ST_OK,      8'd0, 8'd0, 1'b0, 8'd0, 9'd0}},
        '{hta_pkg::REQ_RELEASE, 8'h01, 1'b0, '{hta_pkg::ST_OK,      8'd0, 8'd0, 1'b0, 8'd0, 9'd0}},
        '{hta_pkg::REQ_RELEASE, 8'h04, 1'b0, '{hta_pkg::ST_OK,      8'd0, 8'd0, 1'b0, 8'd0, 9'd0}},
        '{hta_pkg::REQ_RELEASE, 8'h55, 1'b0, '{hta_pkg::ST_OK,      8'd0, 8'd0, 1'b0, 8'd0, 9'd0}},
        '{hta_pkg::REQ_ALLOC,   8'h00, 1'b0, '{hta_pkg::ST_OK,      8'd0, 8'd0, 1'b0, 8'd0, 9'd0}}
    };

    handle_table_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .release_id (release_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .handle_id  (handle_id),
        .slot_index (slot_index),
        .moved      (moved),
        .moved_id   (moved_id),
        .live_count (live_count)
    );

    always #5 clk = ~clk;

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (error_count < 100)
            $display("mismatch at result %0d: %s", result_serial, what);
        error_count++;
    endtask

    // table behavior: lowest free id on allocate, swap-with-last on release
    task automatic apply_request(input logic kind, input logic [7:0] rid,
                                 output handle_result_t r);
        int i;
        int free_id;
        int slot;
        int last;
        int mv_id;
        r.status     = hta_pkg::ST_OK;
        r.handle_id  = '0;
        r.slot_index = '0;
        r.moved      = 1'b0;
        r.moved_id   = '0;
        if (kind == hta_pkg::REQ_ALLOC)
        begin
            free_id = 0;
            for (i = hta_pkg::ID_SPACE - 1; i >= 1; i--)
                if (!live_flag[i])
                    free_id = i;
            if (live_total >= hta_pkg::SLOTS || free_id == 0)
                r.status = hta_pkg::ST_FULL;
            else
            begin
                live_flag[free_id]     = 1'b1;
                slot_of_id[free_id]    = live_total;
                id_in_slot[live_total] = free_id;
                r.handle_id  = 8'(free_id);
                r.slot_index = 8'(live_total);
                live_total++;
            end
        end
        else
        begin
            if (rid == 0 || !live_flag[rid] || live_total == 0)
                r.status = hta_pkg::ST_INVALID;
            else
            begin
                slot = slot_of_id[rid];
                last = live_total - 1;
                // last entry fills the hole
                if (slot != last)
                begin
                    mv_id              = id_in_slot[last];
                    id_in_slot[slot]   = mv_id;
                    slot_of_id[mv_id]  = slot;
                    r.moved    = 1'b1;
                    r.moved_id = 8'(mv_id);
                end
                live_total--;
                live_flag[rid]  = 1'b0;
                slot_of_id[rid] = 0;
                r.handle_id  = rid;
                r.slot_index = 8'(slot);
            end
        end
        r.live_count = 9'(live_total);
    endtask

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 97)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drive one request and wait for it to be taken
    task automatic issue(input logic kind, input logic [7:0] rid, input bit use_literal,
                         input handle_result_t literal);
        int gap;
        handle_result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        release_id <= rid;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_request(kind, rid, predicted);
        if (use_literal)
            pending_results.push_back(literal);
        else
            pending_results.push_back(predicted);
        accepted++;
    endtask

    // random request: allocate, release of a live id, or release of any id
    task automatic random_request(input int alloc_pct, input int live_pct);
        handle_result_t unused;
        unused = '{hta_pkg::ST_OK, 8'd0, 8'd0, 1'b0, 8'd0, 9'd0};
        if ($urandom_range(0, 99) < alloc_pct)
            issue(hta_pkg::REQ_ALLOC, 8'($urandom_range(0, 255)), 1'b0, unused);
        else if (live_total > 0 && $urandom_range(0, 99) < live_pct)
            issue(hta_pkg::REQ_RELEASE, 8'(id_in_slot[$urandom_range(0, live_total - 1)]),
                  1'b0, unused);
        else
            issue(hta_pkg::REQ_RELEASE, 8'($urandom_range(0, 255)), 1'b0, unused);
    endtask

    // sender holds off until every outstanding request has answered
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        idle_on = ($urandom_range(0, 3) != 0);
    endtask

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        int r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end
        else if (stall_run > 0)
            stall_run <= stall_run - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (!idle_on || r < 60)
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(0, 7);
            end
            else if (r < 95)
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(9, 39);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                head_result = pending_results.pop_front();
                if (status !== head_result.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              status, head_result.status));
                if (handle_id !== head_result.handle_id)
                    report_mismatch($sformatf("handle_id %0d, want %0d",
                                              handle_id, head_result.handle_id));
                if (slot_index !== head_result.slot_index)
                    report_mismatch($sformatf("slot_index %0d, want %0d",
                                              slot_index, head_result.slot_index));
                if (moved !== head_result.moved)
                    report_mismatch($sformatf("moved %0d, want %0d",
                                              moved, head_result.moved));
                if (moved_id !== head_result.moved_id)
                    report_mismatch($sformatf("moved_id %0d, want %0d",
                                              moved_id, head_result.moved_id));
                if (live_count !== head_result.live_count)
                    report_mismatch($sformatf("live_count %0d, want %0d",
                                              live_count, head_result.live_count));
            end
            result_serial++;
        end
    end

    // stimulus
    initial
    begin
        int full_tries;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        foreach (plan[k])
            issue(plan[k].kind, plan[k].rid, plan[k].literal, plan[k].want);
        settle();

        // random phases: fill to full, drain to empty, mixed traffic
        while (accepted < ITEM_TARGET)
        begin
            full_tries = 0;
            while (full_tries < 3 && accepted < ITEM_TARGET)
            begin
                if (live_total == hta_pkg::ID_SPACE - 1)
                    full_tries++;
                random_request(85, 70);
            end
            settle();
            while (live_total > 0 && accepted < ITEM_TARGET)
                random_request(8, 85);
            // releases against an empty table
            repeat (2)
                random_request(0, 0);
            settle();
            repeat ($urandom_range(40, 120))
                random_request(50, 75);
            settle();
        end

        // wait out the last results
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
